>>> rtl/sha256_pkg.sv
`default_nettype none
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_COMPRESS,
    ST_PAD_FILL,
    ST_EMIT
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic       store_byte;   // write input byte at fill position
    logic       start_block;  // load working vars, clear round count
    logic       round_step;   // run one round
    logic       finish_block; // fold working vars into hash words
    logic       pad_write;    // write padding byte at pad position
    logic       reinit;       // restore initial hash, clear counters
    logic       emit_shift;   // advance to next digest word
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic       block_full;   // fill position wraps on the stored byte
    logic       rounds_done;  // last round in progress
    logic       pad_last;     // pad position is at the final byte
    logic       pad_extra;    // padded block must be compressed before length
    logic       last_word;    // emitting word 7
  } stat_t;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [63:0] BLOCK_BITS = 64'd512;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

>>> rtl/sha256_ctrl.sv
`default_nettype none
module sha256_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_fire_i,
  input  wire logic               byte_valid_i,
  input  wire logic               message_end_i,
  input  wire logic               out_ready_i,
  input  wire sha256_pkg::stat_t  stat_i,
  output sha256_pkg::cmd_t        cmd_o,
  output logic                    in_ready_o,
  output logic                    out_valid_o
);

  sha256_pkg::state_e state_q, state_d;
  logic end_q, end_d;        // message end pending behind current block
  logic padding_q, padding_d; // current compression is a padded block

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sha256_pkg::ST_COLLECT;
      end_q     <= 1'b0;
      padding_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      end_q     <= end_d;
      padding_q <= padding_d;
    end
  end

  // Next state.
  always_comb begin
    state_d   = state_q;
    end_d     = end_q;
    padding_d = padding_q;
    case (state_q)
      sha256_pkg::ST_COLLECT: begin
        if (in_fire_i) begin
          end_d = message_end_i;
          padding_d = 1'b0;
          if (byte_valid_i && stat_i.block_full) state_d = sha256_pkg::ST_COMPRESS;
          else if (message_end_i) state_d = sha256_pkg::ST_PAD_FILL;
        end
      end
      sha256_pkg::ST_PAD_FILL: begin
        // Pad bytes go in one per cycle; stop at byte 63.
        if (stat_i.pad_last) begin
          state_d   = sha256_pkg::ST_COMPRESS;
          padding_d = 1'b1;
        end
      end
      sha256_pkg::ST_COMPRESS: begin
        if (stat_i.rounds_done) begin
          if (!end_q) state_d = sha256_pkg::ST_COLLECT;
          else if (!padding_q) state_d = sha256_pkg::ST_PAD_FILL;
          else if (stat_i.pad_extra) state_d = sha256_pkg::ST_PAD_FILL;
          else state_d = sha256_pkg::ST_EMIT;
        end
      end
      sha256_pkg::ST_EMIT: begin
        if (out_ready_i && stat_i.last_word) begin
          state_d = sha256_pkg::ST_COLLECT;
          end_d   = 1'b0;
        end
      end
      default: state_d = sha256_pkg::ST_COLLECT;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      sha256_pkg::ST_COLLECT: begin
        in_ready_o       = 1'b1;
        cmd_o.store_byte = in_fire_i && byte_valid_i;
        cmd_o.start_block = in_fire_i && byte_valid_i && stat_i.block_full;
      end
      sha256_pkg::ST_PAD_FILL: begin
        cmd_o.pad_write   = 1'b1;
        cmd_o.start_block = stat_i.pad_last;
      end
      sha256_pkg::ST_COMPRESS: begin
        cmd_o.round_step   = 1'b1;
        cmd_o.finish_block = stat_i.rounds_done;
      end
      sha256_pkg::ST_EMIT: begin
        out_valid_o      = 1'b1;
        cmd_o.emit_shift = out_ready_i;
        cmd_o.reinit     = out_ready_i && stat_i.last_word;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/sha256_dp.sv
`default_nettype none
module sha256_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sha256_pkg::cmd_t  cmd_i,
  input  wire logic [7:0]        data_byte_i,
  output sha256_pkg::stat_t      stat_o,
  output logic [31:0]            digest_word_o,
  output logic [2:0]             word_index_o
);

  logic [31:0] buf_q [16];    // block bytes, first byte in the top lane
  logic [5:0]  fill_q;        // bytes gathered in current block
  logic [63:0] total_q;       // bits in completed blocks
  logic [63:0] bit_len_q;     // message length latched at pad start
  logic [5:0]  pad_pos_q;     // next padding position
  logic        pad_on_q;      // padding in progress
  logic        mark_done_q;   // 0x80 already written
  logic        extra_q;       // padding needs a further block
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];      // message schedule window
  logic [5:0]  round_q;
  logic [2:0]  emit_q;

  logic [31:0] w_cur, w_new, s0, s1, t1, t2, sum0, sum1, ch, maj;
  logic [31:0] v_nxt [8];
  logic        load_w;
  logic [7:0]  pad_byte;
  logic [5:0]  pad_addr;

  // Padding starts where the message left off.
  assign pad_addr = pad_on_q ? pad_pos_q : fill_q;

  // Schedule: first 16 rounds read block words, later ones extend the window.
  assign load_w = (round_q[5:4] == 2'd0);
  assign s0 = sha256_pkg::rotr(w_q[1], 7) ^ sha256_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1 = sha256_pkg::rotr(w_q[14], 17) ^ sha256_pkg::rotr(w_q[14], 19)
            ^ (w_q[14] >> 10);
  assign w_new = s1 + w_q[9] + s0 + w_q[0];
  assign w_cur = load_w ? buf_q[round_q[3:0]] : w_new;

  assign sum1 = sha256_pkg::rotr(v_q[4], 6) ^ sha256_pkg::rotr(v_q[4], 11)
              ^ sha256_pkg::rotr(v_q[4], 25);
  assign ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1   = v_q[7] + sum1 + ch + sha256_pkg::K[round_q] + w_cur;
  assign sum0 = sha256_pkg::rotr(v_q[0], 2) ^ sha256_pkg::rotr(v_q[0], 13)
              ^ sha256_pkg::rotr(v_q[0], 22);
  assign maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2   = sum0 + maj;

  // Working variables after this round.
  always_comb begin
    v_nxt[0] = t1 + t2;
    v_nxt[1] = v_q[0];
    v_nxt[2] = v_q[1];
    v_nxt[3] = v_q[2];
    v_nxt[4] = v_q[3] + t1;
    v_nxt[5] = v_q[4];
    v_nxt[6] = v_q[5];
    v_nxt[7] = v_q[6];
  end

  // Padding byte for the current pad position.
  always_comb begin
    logic [63:0] len;
    len = pad_on_q ? bit_len_q : (total_q + {55'd0, fill_q, 3'd0});
    pad_byte = 8'h00;
    if (!mark_done_q) pad_byte = sha256_pkg::PAD_MARK;
    else if (!extra_q && pad_addr >= sha256_pkg::LEN_POS)
      pad_byte = len[8 * (7 - pad_addr[2:0]) +: 8];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_byte) buf_q[fill_q[5:2]][{~fill_q[1:0], 3'd0} +: 8] <= data_byte_i;
    if (cmd_i.pad_write)  buf_q[pad_addr[5:2]][{~pad_addr[1:0], 3'd0} +: 8] <= pad_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      total_q <= '0;
      bit_len_q <= '0;
      pad_pos_q <= '0;
      pad_on_q <= 1'b0;
      mark_done_q <= 1'b0;
      extra_q <= 1'b0;
      round_q <= '0;
      emit_q <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::H_INIT[i];
    end else begin
      if (cmd_i.store_byte) begin
        fill_q <= fill_q + 6'd1;
        if (fill_q == 6'd63) total_q <= total_q + sha256_pkg::BLOCK_BITS;
      end
      if (cmd_i.pad_write) begin
        if (!pad_on_q) begin
          // First pad cycle: latch length and decide on an extra block.
          pad_on_q  <= 1'b1;
          bit_len_q <= total_q + {55'd0, fill_q, 3'd0};
          extra_q   <= (fill_q >= sha256_pkg::LEN_POS);
        end else if (extra_q && pad_pos_q == 6'd0) begin
          // Length block begins after the extra block.
          extra_q <= 1'b0;
        end
        mark_done_q <= 1'b1;
        pad_pos_q   <= pad_addr + 6'd1;
      end
      if (cmd_i.start_block) round_q <= '0;
      else if (cmd_i.round_step) round_q <= round_q + 6'd1;
      if (cmd_i.finish_block)
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_nxt[i];
      if (cmd_i.emit_shift) emit_q <= emit_q + 3'd1;
      if (cmd_i.reinit) begin
        fill_q <= '0;
        total_q <= '0;
        pad_on_q <= 1'b0;
        mark_done_q <= 1'b0;
        extra_q <= 1'b0;
        emit_q <= '0;
        for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::H_INIT[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_block) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (cmd_i.round_step) begin
      for (int i = 0; i < 8; i++) v_q[i] <= v_nxt[i];
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
      w_q[15] <= w_cur;
    end
  end

  assign stat_o.block_full  = (fill_q == 6'd63);
  assign stat_o.rounds_done = (round_q == 6'd63);
  assign stat_o.pad_last    = (pad_addr == 6'd63);
  assign stat_o.pad_extra   = extra_q;
  assign stat_o.last_word   = (emit_q == 3'd7);

  assign digest_word_o = h_q[emit_q];
  assign word_index_o  = emit_q;

endmodule
`default_nettype wire

>>> rtl/sha256_byte_stream_hasher.sv
`default_nettype none
// SHA-256 over a byte stream. Each input item carries one byte (kept when
// byte_valid is set) and a message_end flag. The item that stores the
// 64th byte of a block starts a compression, one round per cycle in a
// shared round unit, during which input is held off. message_end pads the
// message from the first free byte to byte 63, one byte per cycle, then
// compresses that block; when 56 or more bytes were pending, a further
// padding pass and compression follow for the length block. If the end
// item's byte completes a block, that block's compression comes first and
// padding then fills a whole block. Eight digest words then leave on the
// output stream, word 0 first, tlast on word 7, one per cycle while
// m_axis_tready is high; input reopens the cycle after word 7 is taken,
// with the initial hash values restored.
module sha256_byte_stream_hasher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic [1:0]  s_axis_tuser,   // byte_valid, message_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // digest_word, word_index, zero fill
  output logic             m_axis_tlast    // last_word
);

  sha256_pkg::cmd_t  cmd;
  sha256_pkg::stat_t stat;
  logic        in_fire;
  logic [31:0] digest_word;
  logic [2:0]  word_index;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  sha256_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_fire_i     (in_fire),
    .byte_valid_i  (s_axis_tuser[0]),
    .message_end_i (s_axis_tuser[1]),
    .out_ready_i   (m_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd),
    .in_ready_o    (s_axis_tready),
    .out_valid_o   (m_axis_tvalid)
  );

  sha256_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (s_axis_tdata),
    .stat_o        (stat),
    .digest_word_o (digest_word),
    .word_index_o  (word_index)
  );

  // Hold the word and its index on the bus until taken.
  assign m_axis_tdata = {5'd0, word_index, digest_word};
  assign m_axis_tlast = stat.last_word;

endmodule
`default_nettype wire

>>> rtl/sha256_checker.sv
`default_nettype none
module sha256_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  // Never accept input while a digest is on offer.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("input open during digest");

  // tlast marks word 7 only.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd7)))
    else $error("tlast mismatch");

  // Word index steps by one after a taken non-last word.
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
    (m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1))
    else $error("word index skip");

  // After the last word the input reopens.
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("input not reopened");

endmodule

bind sha256_byte_stream_hasher sha256_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

>>> dv/sha256_byte_stream_hasher_tb.sv
`timescale 1ns / 1ps
module sha256_byte_stream_hasher_tb;

  // Signals for the stream ports of the hasher.
  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // data_byte
  logic [1:0]  s_axis_tuser;   // byte_valid, message_end
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // digest_word, word_index, zero fill
  logic        m_axis_tlast;   // last_word

  sha256_byte_stream_hasher uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam int CYCLE_LIMIT = 400000;

  // Predictor state: the bench's own model of the hash, block buffer and counts.
  logic [31:0] hash_q [8];
  logic [7:0]  blk_q [64];
  int unsigned fill_q;
  logic [63:0] bits_q;

  digest_word_t digest_fifo[$];
  int unsigned  error_count;
  int unsigned  cycle_count;
  int unsigned  out_wait;

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] ror(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_digest();
    for (int i = 0; i < 8; i++) hash_q[i] = INIT_HASH[i];
    fill_q = 0;
    bits_q = '0;
  endfunction

  // Fold the buffered 64-byte block into the running hash.
  function automatic void compress_blk();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int r = 0; r < 16; r++)
      w[r] = {blk_q[4*r], blk_q[4*r+1], blk_q[4*r+2], blk_q[4*r+3]};
    for (int r = 16; r < 64; r++) begin
      s0 = ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3);
      s1 = ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10);
      w[r] = s1 + w[r-7] + s0 + w[r-16];
    end
    for (int i = 0; i < 8; i++) v[i] = hash_q[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_q[i] += v[i];
  endfunction

  // Advance the predictor by one accepted item; queue digest words on end.
  function automatic void predict_hash(logic [7:0] b, logic bv, logic me);
    int unsigned p;
    logic [63:0] len;
    digest_word_t d;
    if (bv) begin
      blk_q[fill_q] = b;
      fill_q++;
      if (fill_q == 64) begin
        compress_blk();
        bits_q += 64'd512;
        fill_q = 0;
      end
    end
    if (!me) return;
    p = fill_q;
    len = bits_q + 64'(p * 8);
    blk_q[p] = 8'h80;
    p++;
    if (p > 56) begin
      while (p < 64) blk_q[p++] = 8'h00;
      compress_blk();
      p = 0;
    end
    while (p < 56) blk_q[p++] = 8'h00;
    for (int j = 0; j < 8; j++) blk_q[56+j] = len[63-8*j -: 8];
    compress_blk();
    for (int j = 0; j < 8; j++) begin
      d.word = hash_q[j];
      d.idx  = 3'(j);
      d.last = (j == 7);
      digest_fifo.push_back(d);
    end
    restart_digest();
  endfunction

  // Drive one item after a random gap, hold it until accepted.
  task automatic send_item(logic [7:0] b, logic bv, logic me);
    int unsigned gap;
    gap = $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= {me, bv};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_hash(b, bv, me);
  endtask

  task automatic send_message(int unsigned len, bit end_with_byte);
    for (int i = 0; i < len; i++)
      send_item(8'($urandom), 1'b1, end_with_byte && (i == len - 1));
    if (!end_with_byte || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Directed: empty message, byte extremes, byte and end together, idle byte.
  task automatic test_directed();
    send_item(8'h00, 1'b0, 1'b1);               // empty message
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);               // byte and end together
    send_item(8'h5a, 1'b0, 1'b0);               // idle byte, ignored
    send_item(8'ha5, 1'b1, 1'b0);
    send_item(8'h3c, 1'b0, 1'b1);               // end with no byte
  endtask

  task automatic test_block_edges();
    send_message(55, 1'b1);                     // fits length in one block
    send_message(56, 1'b0);                     // forces extra block
    send_message(64, 1'b1);                     // byte fills block then pads
  endtask

  task automatic test_random();
    int unsigned n;
    n = 0;
    while (n < 128) begin
      case ($urandom_range(0, 5))
        0: begin
          send_item(8'($urandom), 1'($urandom), 1'($urandom_range(0, 7) == 0));
          n++;
        end
        1: begin
          send_message($urandom_range(50, 70), 1'($urandom));
          n += 60;
        end
        default: begin
          send_message($urandom_range(0, 12), 1'($urandom));
          n += 7;
        end
      endcase
    end
  endtask

  // Output side: random wait before each word, compare each digest word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        digest_word_t e;
        if (digest_fifo.size() == 0) begin
          $display("%0t unexpected digest word: actual %h", $time, m_axis_tdata);
          error_count++;
        end else begin
          e = digest_fifo.pop_front();
          if (m_axis_tdata[31:0] !== e.word || m_axis_tdata[34:32] !== e.idx ||
              m_axis_tdata[39:35] !== 5'd0 || m_axis_tlast !== e.last) begin
            $display("%0t digest mismatch: expected %h idx %0d last %0b, actual %h last %0b",
                     $time, e.word, e.idx, e.last, m_axis_tdata, m_axis_tlast);
            error_count++;
          end
        end
        out_wait = $urandom_range(0, 19);
        m_axis_tready <= (out_wait == 0);
      end else if (out_wait != 0) begin
        out_wait--;
        m_axis_tready <= (out_wait == 0);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    error_count = 0;
    cycle_count = 0;
    out_wait = 0;
    restart_digest();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_block_edges();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (digest_fifo.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/sha256_pkg.sv
rtl/sha256_ctrl.sv
rtl/sha256_dp.sv
rtl/sha256_byte_stream_hasher.sv
rtl/sha256_checker.sv
dv/sha256_byte_stream_hasher_tb.sv
